/* sv/pblalu_pkg.sv */
package pblalu_pkg;

	localparam int LANE_BITS  = 8;
	localparam int WORD_BITS  = 32;
	localparam int WORD_LANES = WORD_BITS / LANE_BITS;
	localparam int CMD_BITS   = 5;
	localparam int IDX_BITS   = 3;
	localparam int CNT_BITS   = 3;
	localparam int PROD_BITS  = 2 * LANE_BITS;
	localparam int SUM_BITS   = LANE_BITS + 2;

	localparam logic [LANE_BITS-1:0] LANE_MAX  = '1;
	localparam logic [LANE_BITS-1:0] CMP_GT    = 8'h01;
	localparam logic [LANE_BITS-1:0] CMP_NGT   = 8'h80;

	// operation codes
	localparam logic [CMD_BITS-1:0] CMD_INC      = 5'd0;
	localparam logic [CMD_BITS-1:0] CMD_DEC      = 5'd1;
	localparam logic [CMD_BITS-1:0] CMD_ADD      = 5'd2;
	localparam logic [CMD_BITS-1:0] CMD_SUB      = 5'd3;
	localparam logic [CMD_BITS-1:0] CMD_INC_SAT  = 5'd4;
	localparam logic [CMD_BITS-1:0] CMD_DEC_SAT  = 5'd5;
	localparam logic [CMD_BITS-1:0] CMD_ADD_SAT  = 5'd6;
	localparam logic [CMD_BITS-1:0] CMD_SUB_SAT  = 5'd7;
	localparam logic [CMD_BITS-1:0] CMD_ABS_DIFF = 5'd8;
	localparam logic [CMD_BITS-1:0] CMD_CMP      = 5'd9;
	localparam logic [CMD_BITS-1:0] CMD_EQ       = 5'd10;
	localparam logic [CMD_BITS-1:0] CMD_NE       = 5'd11;
	localparam logic [CMD_BITS-1:0] CMD_GT       = 5'd12;
	localparam logic [CMD_BITS-1:0] CMD_GE       = 5'd13;
	localparam logic [CMD_BITS-1:0] CMD_LT       = 5'd14;
	localparam logic [CMD_BITS-1:0] CMD_LE       = 5'd15;
	localparam logic [CMD_BITS-1:0] CMD_ZERO     = 5'd16;
	localparam logic [CMD_BITS-1:0] CMD_NONZERO  = 5'd17;
	localparam logic [CMD_BITS-1:0] CMD_GET      = 5'd18;
	localparam logic [CMD_BITS-1:0] CMD_SET      = 5'd19;
	localparam logic [CMD_BITS-1:0] CMD_PLACE    = 5'd20;
	localparam logic [CMD_BITS-1:0] CMD_SELECT   = 5'd21;
	localparam logic [CMD_BITS-1:0] CMD_MERGE    = 5'd22;
	localparam logic [CMD_BITS-1:0] CMD_BLEND    = 5'd23;
	localparam logic [CMD_BITS-1:0] CMD_SUM      = 5'd24;
	localparam logic [CMD_BITS-1:0] CMD_WSUM     = 5'd25;

	// configuration register indexes
	localparam logic [1:0] REG_LANE_COUNT = 2'd0;
	localparam logic [1:0] REG_REVERSE    = 2'd1;

	localparam logic [CNT_BITS-1:0] LANES_THREE = 3'd3;
	localparam logic [CNT_BITS-1:0] LANES_RESET = 3'd4;

	typedef struct packed {
		logic [LANE_BITS-1:0] val;
		logic [PROD_BITS-1:0] prod;
		logic                 use_div;
	} lane_res_t;

	typedef struct packed {
		logic [CMD_BITS-1:0]  cmd;
		logic [WORD_BITS-1:0] a;
		logic [LANE_BITS-1:0] vb;
		logic [IDX_BITS-1:0]  idx;
		logic [CNT_BITS-1:0]  n;
		logic                 rev;
	} ctrl_t;

	// floor(x / 255) for x up to 255 * 255: estimate, then one correction step
	function automatic logic [LANE_BITS-1:0] div255(input logic [PROD_BITS-1:0] x);
		logic [PROD_BITS:0] t;
		logic [LANE_BITS:0] q0;
		logic [PROD_BITS:0] r;
		t  = {1'b0, x} + {{(LANE_BITS+1){1'b0}}, x[PROD_BITS-1:LANE_BITS]};
		q0 = t[PROD_BITS:LANE_BITS];
		r  = {1'b0, x} - ({q0, {LANE_BITS{1'b0}}} - {{LANE_BITS{1'b0}}, q0});
		if (r >= {{(LANE_BITS+1){1'b0}}, LANE_MAX}) begin
			q0 = q0 + 1'b1;
		end
		return q0[LANE_BITS-1:0];
	endfunction

endpackage

/* sv/pblalu_lane.sv */
module pblalu_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic [pblalu_pkg::CMD_BITS-1:0]     cmd,
	input  logic [pblalu_pkg::LANE_BITS-1:0]    a,
	input  logic [pblalu_pkg::LANE_BITS-1:0]    b,
	input  logic [pblalu_pkg::LANE_BITS-1:0]    p,
	input  logic                                sel,
	input  logic                                active,
	output pblalu_pkg::lane_res_t               res_s1
);

	localparam int LB = pblalu_pkg::LANE_BITS;
	localparam int PB = pblalu_pkg::PROD_BITS;

	logic [LB:0]   sum;
	logic [LB:0]   diff;
	logic          gt;
	logic          eq;
	logic [LB-1:0] mask_gt;
	logic [LB-1:0] fn_val;
	logic [PB-1:0] m1;
	logic [PB-1:0] m2;
	pblalu_pkg::lane_res_t res;

	assign sum  = {1'b0, a} + {1'b0, b};
	assign diff = {1'b0, a} - {1'b0, b};
	assign gt   = a > b;
	assign eq   = a == b;
	assign mask_gt = gt ? pblalu_pkg::LANE_MAX : '0;

	// one product per lane, plus the complementary weight for blends
	assign m1 = PB'((cmd == pblalu_pkg::CMD_BLEND) ? b : a) * PB'(p);
	assign m2 = PB'(a) * PB'(pblalu_pkg::LANE_MAX - p);

	always_comb begin
		unique case (cmd)
			pblalu_pkg::CMD_INC:      fn_val = a + 1'b1;
			pblalu_pkg::CMD_DEC:      fn_val = a - 1'b1;
			pblalu_pkg::CMD_ADD:      fn_val = sum[LB-1:0];
			pblalu_pkg::CMD_SUB:      fn_val = diff[LB-1:0];
			pblalu_pkg::CMD_INC_SAT:
				fn_val = (a == pblalu_pkg::LANE_MAX) ? a : a + 1'b1;
			pblalu_pkg::CMD_DEC_SAT:  fn_val = (a == '0) ? a : a - 1'b1;
			pblalu_pkg::CMD_ADD_SAT:
				fn_val = sum[LB] ? pblalu_pkg::LANE_MAX : sum[LB-1:0];
			pblalu_pkg::CMD_SUB_SAT:  fn_val = gt ? diff[LB-1:0] : '0;
			pblalu_pkg::CMD_ABS_DIFF: fn_val = gt ? diff[LB-1:0] : b - a;
			pblalu_pkg::CMD_CMP:
				fn_val = gt ? pblalu_pkg::CMP_GT : pblalu_pkg::CMP_NGT;
			pblalu_pkg::CMD_EQ:       fn_val = eq ? pblalu_pkg::LANE_MAX : '0;
			pblalu_pkg::CMD_NE:       fn_val = eq ? '0 : pblalu_pkg::LANE_MAX;
			pblalu_pkg::CMD_GT:       fn_val = mask_gt;
			pblalu_pkg::CMD_GE:       fn_val = (gt || eq) ? pblalu_pkg::LANE_MAX : '0;
			pblalu_pkg::CMD_LT:       fn_val = (gt || eq) ? '0 : pblalu_pkg::LANE_MAX;
			pblalu_pkg::CMD_LE:       fn_val = ~mask_gt;
			pblalu_pkg::CMD_ZERO:     fn_val = (a == '0) ? pblalu_pkg::LANE_MAX : '0;
			pblalu_pkg::CMD_NONZERO:  fn_val = (a == '0) ? '0 : pblalu_pkg::LANE_MAX;
			default:                  fn_val = '0;
		endcase
	end

	always_comb begin
		res.val     = '0;
		res.prod    = '0;
		res.use_div = 1'b0;
		unique case (cmd)
			pblalu_pkg::CMD_SELECT: res.val = (active && sel) ? a : '0;
			pblalu_pkg::CMD_MERGE:  res.val = (active && sel) ? b : a;
			pblalu_pkg::CMD_BLEND: begin
				res.val     = a;
				res.prod    = m1 + m2;
				res.use_div = active && sel;
			end
			pblalu_pkg::CMD_SUM:    res.val = active ? a : '0;
			pblalu_pkg::CMD_WSUM: begin
				res.prod    = active ? m1 : '0;
				res.use_div = 1'b1;
			end
			default:                res.val = active ? fn_val : '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= res;
		end
	end

endmodule

/* sv/pblalu_merge.sv */
module pblalu_merge #(
	parameter int MAX_LANES = 4
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  pblalu_pkg::ctrl_t                       ctrl_s1,
	input  pblalu_pkg::lane_res_t [MAX_LANES-1:0]   lane_s1,
	output logic [pblalu_pkg::WORD_BITS-1:0]        result_s2
);

	localparam int LB = pblalu_pkg::LANE_BITS;
	localparam int WL = pblalu_pkg::WORD_LANES;
	localparam int SB = pblalu_pkg::SUM_BITS;

	logic [WL-1:0][LB-1:0] packed_w;
	logic [WL-1:0][LB-1:0] set_w;
	logic [WL-1:0][LB-1:0] place_w;
	logic [LB-1:0]         get_v;
	logic [SB-1:0]         sum_v;
	logic [SB-1:0]         wsum_v;
	logic                  idx_ok;
	logic [pblalu_pkg::CNT_BITS-1:0] pos;
	logic [pblalu_pkg::WORD_BITS-1:0] result;
	logic [LB-1:0]         q;
	logic [LB-1:0]         a_byte;

	assign idx_ok = pblalu_pkg::CNT_BITS'(ctrl_s1.idx) < ctrl_s1.n;
	assign pos    = ctrl_s1.rev ? ctrl_s1.n - 1'b1 - pblalu_pkg::CNT_BITS'(ctrl_s1.idx)
	                            : pblalu_pkg::CNT_BITS'(ctrl_s1.idx);

	always_comb begin
		packed_w = '0;
		set_w    = '0;
		place_w  = '0;
		get_v    = '0;
		sum_v    = '0;
		wsum_v   = '0;
		q        = '0;
		a_byte   = '0;
		for (int k = 0; k < WL; k++) begin
			a_byte = ctrl_s1.a[k*LB +: LB];
			if (k < MAX_LANES) begin
				q = pblalu_pkg::div255(lane_s1[k].prod);
				packed_w[k] = lane_s1[k].use_div ? q : lane_s1[k].val;
				sum_v  = sum_v + SB'(lane_s1[k].val);
				wsum_v = wsum_v + SB'(q);
			end else begin
				// bytes past the lanes keep operand a for merge and blend
				packed_w[k] = (ctrl_s1.cmd == pblalu_pkg::CMD_MERGE ||
				               ctrl_s1.cmd == pblalu_pkg::CMD_BLEND) ? a_byte : '0;
			end
			if (pos == pblalu_pkg::CNT_BITS'(k)) begin
				set_w[k]   = ctrl_s1.vb;
				place_w[k] = ctrl_s1.vb;
				get_v      = a_byte;
			end else begin
				set_w[k]   = a_byte;
			end
		end
	end

	always_comb begin
		if (ctrl_s1.cmd <= pblalu_pkg::CMD_NONZERO) begin
			result = packed_w;
		end else begin
			unique case (ctrl_s1.cmd)
				pblalu_pkg::CMD_GET:    result = idx_ok ? 32'(get_v) : '0;
				pblalu_pkg::CMD_SET:    result = idx_ok ? set_w : '0;
				pblalu_pkg::CMD_PLACE:  result = idx_ok ? place_w : '0;
				pblalu_pkg::CMD_SELECT,
				pblalu_pkg::CMD_MERGE,
				pblalu_pkg::CMD_BLEND:  result = packed_w;
				pblalu_pkg::CMD_SUM:    result = 32'(sum_v);
				pblalu_pkg::CMD_WSUM:   result = 32'(wsum_v);
				default:                result = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s2 <= result;
		end
	end

endmodule

/* sv/packed_byte_lane_alu_unit.sv */
// packed byte-lane alu: one lane unit per byte, a merge stage, an output register
// the result passes the stage-one registers (lane results, ctrl_s1) and the merge register result_s2
// throughput: one transaction per cycle while the output is taken; the two stage
//   registers hold while the next stage is full; input stops only once both are full
// reset: arst_n clears the stage valid bits, lane_count to 4 and reverse_lane_order to 0
module packed_byte_lane_alu_unit #(
	parameter int MAX_LANES = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// operand_a, operand_b, select_mask, alpha_word, lane_index, zero fill
	input  logic [135:0] s_axis_tdata,
	// command
	input  logic [4:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result
	output logic [31:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [2:0]   cfg_data
);

	localparam int LB = pblalu_pkg::LANE_BITS;
	localparam int WB = pblalu_pkg::WORD_BITS;

	logic [pblalu_pkg::CNT_BITS-1:0] lane_count_q;
	logic                            reverse_q;
	logic                            valid_s1;
	logic                            valid_s2;
	logic                            en1;
	logic                            en2;
	logic [pblalu_pkg::CNT_BITS-1:0] n;
	logic [WB-1:0]                   a;
	logic [WB-1:0]                   b;
	logic [WB-1:0]                   sel;
	logic [WB-1:0]                   alpha;
	logic [pblalu_pkg::IDX_BITS-1:0] idx;
	pblalu_pkg::ctrl_t               ctrl_s1;
	pblalu_pkg::lane_res_t [MAX_LANES-1:0] lane_s1;

	assign a     = s_axis_tdata[WB-1:0];
	assign b     = s_axis_tdata[2*WB-1:WB];
	assign sel   = s_axis_tdata[3*WB-1:2*WB];
	assign alpha = s_axis_tdata[4*WB-1:3*WB];
	assign idx   = s_axis_tdata[4*WB +: pblalu_pkg::IDX_BITS];

	assign n = (lane_count_q == pblalu_pkg::LANES_THREE) ? pblalu_pkg::LANES_THREE
	                                                      : pblalu_pkg::CNT_BITS'(MAX_LANES);

	assign en2           = !valid_s2 || m_axis_tready;
	assign en1           = !valid_s1 || en2;
	assign s_axis_tready = en1;
	assign m_axis_tvalid = valid_s2;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_count_q <= pblalu_pkg::LANES_RESET;
			reverse_q    <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == pblalu_pkg::REG_LANE_COUNT) begin
				lane_count_q <= cfg_data;
			end else if (cfg_index == pblalu_pkg::REG_REVERSE) begin
				reverse_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ctrl_s1.cmd <= s_axis_tuser;
			ctrl_s1.a   <= a;
			ctrl_s1.vb  <= b[LB-1:0];
			ctrl_s1.idx <= idx;
			ctrl_s1.n   <= n;
			ctrl_s1.rev <= reverse_q;
		end
	end

	for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
		pblalu_lane u_lane (
			.clk    (clk),
			.en     (en1),
			.cmd    (s_axis_tuser),
			.a      (a[k*LB +: LB]),
			.b      (b[k*LB +: LB]),
			.p      (alpha[k*LB +: LB]),
			.sel    (|sel[k*LB +: LB]),
			.active (pblalu_pkg::CNT_BITS'(k) < n),
			.res_s1 (lane_s1[k])
		);
	end

	pblalu_merge #(
		.MAX_LANES (MAX_LANES)
	) u_merge (
		.clk       (clk),
		.en        (en2),
		.ctrl_s1   (ctrl_s1),
		.lane_s1   (lane_s1),
		.result_s2 (m_axis_tdata)
	);

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT    = 600000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 130;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 6;
	localparam int MAX_REPORTS    = 10;

	localparam int CMD_BITS   = pblalu_pkg::CMD_BITS;
	localparam int WORD_BITS  = pblalu_pkg::WORD_BITS;
	localparam int IDX_BITS   = pblalu_pkg::IDX_BITS;
	localparam int CNT_BITS   = pblalu_pkg::CNT_BITS;
	localparam int WORD_LANES = pblalu_pkg::WORD_LANES;
	localparam int LANE_TOP   = int'(pblalu_pkg::LANE_MAX);

	localparam logic [CMD_BITS-1:0] CMD_UNUSED_TOP = '1;
	localparam logic [CNT_BITS-1:0] LANES_CODE_MIN = '0;
	localparam logic [CNT_BITS-1:0] LANES_CODE_MAX = '1;

	typedef struct packed {
		logic [CMD_BITS-1:0]  cmd;
		logic [WORD_BITS-1:0] a;
		logic [WORD_BITS-1:0] b;
		logic [WORD_BITS-1:0] sel;
		logic [WORD_BITS-1:0] alpha;
		logic [IDX_BITS-1:0]  idx;
		logic                 known;
		logic [WORD_BITS-1:0] res;
	} vec_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic [4:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [2:0]   cfg_data;

	// shadow of the configuration registers
	logic [CNT_BITS-1:0]  lane_cnt = pblalu_pkg::LANES_RESET;
	logic                 rev_order = 1'b0;

	logic [WORD_BITS-1:0] result_q[$];
	vec_row_t             directed_q[$];
	logic [WORD_BITS-1:0] want_res;
	int                   fail_cnt = 0;
	int                   cycle_cnt = 0;
	bit                   gapless = 1'b0;
	bit                   rx_hold_req = 1'b0;

	packed_byte_lane_alu_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [WORD_BITS-1:0] alu_predict(
		input logic [CMD_BITS-1:0]  cmd,
		input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b,
		input logic [WORD_BITS-1:0] sel,
		input logic [WORD_BITS-1:0] alpha,
		input logic [IDX_BITS-1:0]  idx
	);
		int lanes;
		int pos;
		int k;
		int x;
		int y;
		int p;
		int acc;
		logic [WORD_BITS-1:0] r;
		lanes = (lane_cnt == pblalu_pkg::LANES_THREE) ? 3 : WORD_LANES;
		r = '0;
		acc = 0;
		if (cmd <= pblalu_pkg::CMD_NONZERO) begin
			for (k = 0; k < lanes; k++) begin
				x = int'(a[8*k +: 8]);
				y = int'(b[8*k +: 8]);
				case (cmd)
					pblalu_pkg::CMD_INC:      acc = x + 1;
					pblalu_pkg::CMD_DEC:      acc = x - 1;
					pblalu_pkg::CMD_ADD:      acc = x + y;
					pblalu_pkg::CMD_SUB:      acc = x - y;
					pblalu_pkg::CMD_INC_SAT:  acc = (x == LANE_TOP) ? LANE_TOP : x + 1;
					pblalu_pkg::CMD_DEC_SAT:  acc = (x > 1) ? x - 1 : 0;
					pblalu_pkg::CMD_ADD_SAT:  acc = (x + y > LANE_TOP) ? LANE_TOP : x + y;
					pblalu_pkg::CMD_SUB_SAT:  acc = (x > y) ? x - y : 0;
					pblalu_pkg::CMD_ABS_DIFF: acc = (x > y) ? x - y : y - x;
					pblalu_pkg::CMD_CMP:
						acc = (x > y) ? int'(pblalu_pkg::CMP_GT) : int'(pblalu_pkg::CMP_NGT);
					pblalu_pkg::CMD_EQ:       acc = (x == y) ? LANE_TOP : 0;
					pblalu_pkg::CMD_NE:       acc = (x != y) ? LANE_TOP : 0;
					pblalu_pkg::CMD_GT:       acc = (x > y) ? LANE_TOP : 0;
					pblalu_pkg::CMD_GE:       acc = (x >= y) ? LANE_TOP : 0;
					pblalu_pkg::CMD_LT:       acc = (x < y) ? LANE_TOP : 0;
					pblalu_pkg::CMD_LE:       acc = (x <= y) ? LANE_TOP : 0;
					pblalu_pkg::CMD_ZERO:     acc = (x == 0) ? LANE_TOP : 0;
					pblalu_pkg::CMD_NONZERO:  acc = (x != 0) ? LANE_TOP : 0;
					default:                  acc = 0;
				endcase
				r[8*k +: 8] = acc[7:0];
			end
		end else if (cmd <= pblalu_pkg::CMD_PLACE) begin
			if (int'(idx) < lanes) begin
				pos = rev_order ? lanes - 1 - int'(idx) : int'(idx);
				if (cmd == pblalu_pkg::CMD_GET) begin
					r[7:0] = a[8*pos +: 8];
				end else begin
					if (cmd == pblalu_pkg::CMD_SET) begin
						r = a;
					end
					r[8*pos +: 8] = b[7:0];
				end
			end
		end else if (cmd <= pblalu_pkg::CMD_BLEND) begin
			r = (cmd == pblalu_pkg::CMD_SELECT) ? '0 : a;
			for (k = 0; k < lanes; k++) begin
				if (sel[8*k +: 8] != 0) begin
					x = int'(a[8*k +: 8]);
					y = int'(b[8*k +: 8]);
					p = int'(alpha[8*k +: 8]);
					if (cmd == pblalu_pkg::CMD_SELECT) begin
						acc = x;
					end else if (cmd == pblalu_pkg::CMD_MERGE) begin
						acc = y;
					end else begin
						acc = (y * p + x * (LANE_TOP - p)) / LANE_TOP;
					end
					r[8*k +: 8] = acc[7:0];
				end
			end
		end else if (cmd == pblalu_pkg::CMD_SUM || cmd == pblalu_pkg::CMD_WSUM) begin
			for (k = 0; k < lanes; k++) begin
				x = int'(a[8*k +: 8]);
				p = int'(alpha[8*k +: 8]);
				acc += (cmd == pblalu_pkg::CMD_SUM) ? x : (x * p) / LANE_TOP;
			end
			r = WORD_BITS'(acc);
		end
		return r;
	endfunction

	// bytes biased towards the lane extremes
	function automatic logic [WORD_BITS-1:0] rand_word(input int zero_tenths);
		logic [WORD_BITS-1:0] w;
		int k;
		for (k = 0; k < WORD_LANES; k++) begin
			if ($urandom_range(0, 9) < zero_tenths) begin
				w[8*k +: 8] = 8'h00;
			end else begin
				case ($urandom_range(0, 7))
					0:       w[8*k +: 8] = 8'h00;
					1:       w[8*k +: 8] = 8'hFF;
					2:       w[8*k +: 8] = 8'h01;
					3:       w[8*k +: 8] = 8'hFE;
					4:       w[8*k +: 8] = 8'h80;
					5:       w[8*k +: 8] = 8'h7F;
					default: w[8*k +: 8] = 8'($urandom_range(0, 255));
				endcase
			end
		end
		return w;
	endfunction

	task automatic log_mismatch(input string what, input logic [WORD_BITS-1:0] want,
		input logic [WORD_BITS-1:0] got);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTS) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
		end
	endtask

	task automatic add_row(input logic [CMD_BITS-1:0] cmd, input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b, input logic [WORD_BITS-1:0] sel,
		input logic [WORD_BITS-1:0] alpha, input logic [IDX_BITS-1:0] idx,
		input logic known, input logic [WORD_BITS-1:0] res);
		vec_row_t row;
		row.cmd = cmd;
		row.a = a;
		row.b = b;
		row.sel = sel;
		row.alpha = alpha;
		row.idx = idx;
		row.known = known;
		row.res = res;
		directed_q.push_back(row);
	endtask

	task automatic send_op(input logic [CMD_BITS-1:0] cmd, input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b, input logic [WORD_BITS-1:0] sel,
		input logic [WORD_BITS-1:0] alpha, input logic [IDX_BITS-1:0] idx,
		input logic [WORD_BITS-1:0] want);
		int gap;
		gap = gapless ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, idx, alpha, sel, b, a};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		result_q.push_back(want);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [CNT_BITS-1:0] lanes, input logic rev);
		cfg_valid <= 1'b1;
		cfg_index <= pblalu_pkg::REG_LANE_COUNT;
		cfg_data  <= lanes;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= pblalu_pkg::REG_REVERSE;
		cfg_data  <= {2'b0, rev};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		lane_cnt = lanes;
		rev_order = rev;
	endtask

	// stimulus side
	initial begin
		logic [CMD_BITS-1:0]  cmd;
		logic [WORD_BITS-1:0] a;
		logic [WORD_BITS-1:0] b;
		logic [WORD_BITS-1:0] sel;
		logic [WORD_BITS-1:0] alpha;
		logic [IDX_BITS-1:0]  idx;
		logic [CNT_BITS-1:0]  lanes;
		logic                 rev;
		vec_row_t             row;
		int                   ph;
		int                   i;
		int                   k;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= pblalu_pkg::REG_LANE_COUNT;
		cfg_data      <= pblalu_pkg::LANES_RESET;

		// four lanes, natural order
		add_row(pblalu_pkg::CMD_INC, 32'hFFFF_FFFF, '0, '0, '0, '0, 1'b1, 32'h0000_0000);
		add_row(pblalu_pkg::CMD_DEC, 32'h0000_0000, '0, '0, '0, '0, 1'b1, 32'hFFFF_FFFF);
		add_row(pblalu_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0101_0101, '0, '0, '0, 1'b1,
			32'h0000_0000);
		add_row(pblalu_pkg::CMD_SUB, 32'h0000_0000, 32'h0101_0101, '0, '0, '0, 1'b1,
			32'hFFFF_FFFF);
		add_row(pblalu_pkg::CMD_INC_SAT, 32'hFF00_FF00, '0, '0, '0, '0, 1'b1, 32'hFF01_FF01);
		add_row(pblalu_pkg::CMD_DEC_SAT, 32'h0001_0200, '0, '0, '0, '0, 1'b1, 32'h0000_0100);
		add_row(pblalu_pkg::CMD_ADD_SAT, 32'hFF80_FF01, 32'h0180_8000, '0, '0, '0, 1'b1,
			32'hFFFF_FF01);
		add_row(pblalu_pkg::CMD_SUB_SAT, 32'h0080_0010, 32'h0140_0020, '0, '0, '0, 1'b1,
			32'h0040_0000);
		add_row(pblalu_pkg::CMD_ABS_DIFF, 32'h00FF_1020, 32'hFF00_2010, '0, '0, '0, 1'b1,
			32'hFFFF_1010);
		add_row(pblalu_pkg::CMD_CMP, 32'hFF00_8080, 32'h00FF_807F, '0, '0, '0, 1'b1,
			32'h0180_8001);
		add_row(pblalu_pkg::CMD_EQ, 32'h00FF_8010, 32'h0010_8010, '0, '0, '0, 1'b1,
			32'hFF00_FFFF);
		add_row(pblalu_pkg::CMD_NE, 32'h00FF_8010, 32'h0010_8011, '0, '0, '0, 1'b0, '0);
		add_row(pblalu_pkg::CMD_GT, 32'h00FF_8010, 32'h0110_8011, '0, '0, '0, 1'b0, '0);
		add_row(pblalu_pkg::CMD_GE, 32'h00FF_8010, 32'h0110_8011, '0, '0, '0, 1'b0, '0);
		add_row(pblalu_pkg::CMD_LT, 32'h00FF_8010, 32'h0110_8011, '0, '0, '0, 1'b0, '0);
		add_row(pblalu_pkg::CMD_LE, 32'h00FF_8010, 32'h0110_8011, '0, '0, '0, 1'b0, '0);
		add_row(pblalu_pkg::CMD_ZERO, 32'h00FF_0001, '0, '0, '0, '0, 1'b0, '0);
		add_row(pblalu_pkg::CMD_NONZERO, 32'h00FF_0001, '0, '0, '0, '0, 1'b0, '0);
		add_row(pblalu_pkg::CMD_GET, 32'h1122_3344, '0, '0, '0, 3'd3, 1'b1, 32'h0000_0011);
		add_row(pblalu_pkg::CMD_GET, 32'h1122_3344, '0, '0, '0, 3'd4, 1'b1, 32'h0000_0000);
		add_row(pblalu_pkg::CMD_SET, 32'h1122_3344, 32'h0000_00AB, '0, '0, 3'd1, 1'b1,
			32'h1122_AB44);
		add_row(pblalu_pkg::CMD_SET, 32'h1122_3344, 32'hFFFF_FFAB, '0, '0, 3'd7, 1'b1,
			32'h0000_0000);
		add_row(pblalu_pkg::CMD_PLACE, 32'hFFFF_FFFF, 32'hFFFF_FFAB, '0, '0, 3'd0, 1'b1,
			32'h0000_00AB);
		add_row(pblalu_pkg::CMD_SELECT, 32'h1122_3344, '0, 32'h00FF_0001, '0, '0, 1'b1,
			32'h0022_0044);
		add_row(pblalu_pkg::CMD_MERGE, 32'h1122_3344, 32'hAABB_CCDD, 32'h8000_0100, '0, '0,
			1'b0, '0);
		add_row(pblalu_pkg::CMD_BLEND, 32'h00FF_00FF, 32'hFF00_FF00, 32'hFFFF_FFFF,
			32'h00FF_807F, '0, 1'b0, '0);
		add_row(pblalu_pkg::CMD_SUM, 32'hFFFF_FFFF, '0, '0, '0, '0, 1'b1, 32'h0000_03FC);
		add_row(pblalu_pkg::CMD_WSUM, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF, '0, 1'b1,
			32'h0000_03FC);
		add_row(CMD_UNUSED_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			3'd7, 1'b1, 32'h0000_0000);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i]) begin
			row = directed_q[i];
			send_op(row.cmd, row.a, row.b, row.sel, row.alpha, row.idx,
				row.known ? row.res :
				alu_predict(row.cmd, row.a, row.b, row.sel, row.alpha, row.idx));
		end
		wait_idle();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin lanes = pblalu_pkg::LANES_RESET; rev = 1'b1; end
				1: begin lanes = pblalu_pkg::LANES_THREE; rev = 1'b0; end
				2: begin lanes = LANES_CODE_MAX;          rev = 1'b1; end
				3: begin lanes = LANES_CODE_MIN;          rev = 1'b0; end
				4: begin lanes = pblalu_pkg::LANES_THREE; rev = 1'b1; end
				default: begin
					lanes = CNT_BITS'($urandom_range(0, 7));
					rev = ($urandom_range(0, 1) != 0);
				end
			endcase
			set_config(lanes, rev);
			gapless = (ph == 1 || ph == 5);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				// receiver stalls long while items keep coming
				if (ph == 2 && i == 20) begin
					rx_hold_req = 1'b1;
				end
				if (ph == 3 && i == 60) begin
					wait_idle();
				end
				cmd = ($urandom_range(0, 9) == 0) ? CMD_BITS'($urandom_range(0, 31))
					: CMD_BITS'($urandom_range(0, int'(pblalu_pkg::CMD_WSUM)));
				a = rand_word(1);
				b = rand_word(1);
				for (k = 0; k < WORD_LANES; k++) begin
					if ($urandom_range(0, 9) < 3) begin
						b[8*k +: 8] = a[8*k +: 8];
					end
				end
				sel = rand_word(4);
				alpha = rand_word(1);
				idx = IDX_BITS'($urandom_range(0, 7));
				send_op(cmd, a, b, sel, alpha, idx, alu_predict(cmd, a, b, sel, alpha, idx));
			end
			wait_idle();
		end

		if (fail_cnt == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// result side back-pressure
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				stall = RX_HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end else begin
				stall = gapless ? 0 : $urandom_range(0, 14);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (result_q.size() == 0) begin
				log_mismatch("unexpected transaction", 'x, m_axis_tdata);
			end else begin
				want_res = result_q.pop_front();
				if (m_axis_tdata !== want_res) begin
					log_mismatch("result", want_res, m_axis_tdata);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
